FILE: design/pts_pkg.sv
// shared types and constants for the process table scheduler
`default_nettype none
package pts_pkg;
    localparam int SLOTS = 64;
    localparam int LEVELS = 3;
    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(LEVELS);
    localparam int ENT_W = 3 + 2 + 31 + 32 * 4;

    localparam logic [2:0] FN_SET_STATE = 3'd0;
    localparam logic [2:0] FN_SET_PRIO  = 3'd1;
    localparam logic [2:0] FN_LOWER     = 3'd2;
    localparam logic [2:0] FN_ALLOC     = 3'd3;
    localparam logic [2:0] FN_TICK      = 3'd4;
    localparam logic [2:0] FN_SELECT    = 3'd5;
    localparam logic [2:0] FN_REAP      = 3'd6;
    localparam logic [2:0] FN_NOP       = 3'd7;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_EMBRYO   = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [1:0] RS_OK    = 2'd0;
    localparam logic [1:0] RS_NONE  = 2'd1;
    localparam logic [1:0] RS_RANGE = 2'd2;

    localparam logic [1:0] PM_ROTATE = 2'd0;
    localparam logic [1:0] PM_OLDEST = 2'd1;
    localparam logic [1:0] PM_PRIO   = 2'd2;
    localparam logic [1:0] PM_LEVELS = 2'd3;

    typedef struct packed {
        logic [2:0]  state;
        logic [1:0]  prio;
        logic [30:0] id;
        logic [31:0] created;
        logic [31:0] ready_cnt;
        logic [31:0] run_cnt;
        logic [31:0] sleep_cnt;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  chosen_slot;
        logic [30:0] task_id;
        logic [31:0] wait_ticks;
        logic [31:0] run_ticks;
        logic [31:0] sleep_ticks;
    } result_t;
endpackage
`default_nettype wire

FILE: design/process_table_scheduler_unit.sv
// Process table scheduler: one request at a time against a 64-entry slot RAM.
// Clearing pass after reset: no request accepted meanwhile.
// Point operations (set state, priorities, reap) read then write one slot; allocate, tick
// and select sweep the slots through the single RAM read port; allocate and first-hit
// selects stop at a hit; multilevel select rescans per empty level, up to LEVELS sweeps.
// Result is held in an output register; rst_n clears control state at once.
`default_nettype none
module process_table_scheduler_unit
    import pts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    input  wire logic [5:0]  slot_index,
    input  wire logic [2:0]  new_state,
    input  wire logic [2:0]  priority_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [5:0]       chosen_slot,
    output logic [30:0]      task_id,
    output logic [31:0]      wait_ticks,
    output logic [31:0]      run_ticks,
    output logic [31:0]      sleep_ticks
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_RD    = 8'b00000100,
        S_PT    = 8'b00001000,
        S_SCAN  = 8'b00010000,
        S_FIN   = 8'b00100000,
        S_UPD   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  policy_reg;
    logic [2:0]  func_reg;
    logic [SW-1:0] idx_reg;
    logic [2:0]  nst_reg, pri_reg;
    logic [30:0] next_id_reg;
    logic [31:0] tick_reg;
    logic [SW-1:0] rot_reg;
    logic [SW-1:0] lvl_ptr_reg [LEVELS];
    logic [SW:0]   cnt_reg;        // issue counter
    logic [SW:0]   rcnt_reg;       // returned-data counter
    logic [SW-1:0] raddr_reg;      // address presented last cycle
    logic          rvalid_reg;
    logic          found_reg;
    logic [SW-1:0] best_reg;
    logic [1:0]    bprio_reg;
    logic [31:0]   bcre_reg;
    logic [30:0]   bid_reg;
    logic [LW:0]   lvl_reg;        // current level 1..LEVELS
    logic [SW-1:0] base_reg;
    result_t       res_reg;
    logic          out_valid_reg;

    logic          we;
    logic [SW-1:0] waddr, raddr;
    entry_t        wdata, rdata;

    pts_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status      = res_reg.status;
    assign chosen_slot = res_reg.chosen_slot;
    assign task_id     = res_reg.task_id;
    assign wait_ticks  = res_reg.wait_ticks;
    assign run_ticks   = res_reg.run_ticks;
    assign sleep_ticks = res_reg.sleep_ticks;

    // candidate test on returned entry
    logic cand, better;
    always_comb
    begin
        cand = 1'b0;
        better = 1'b0;
        case (func_reg)
            FN_ALLOC:  cand = (rdata.state == ST_UNUSED);
            FN_SELECT:
            begin
                cand = (rdata.state == ST_RUNNABLE);
                if (policy_reg == PM_LEVELS)
                    cand = cand && ({1'b0, rdata.prio} == 3'(lvl_reg));
            end
            default:   cand = 1'b0;
        endcase
        if (!found_reg)
            better = cand;
        else if (func_reg == FN_SELECT && (policy_reg == PM_OLDEST || policy_reg == PM_PRIO))
        begin
            if (policy_reg == PM_PRIO && rdata.prio != bprio_reg)
                better = cand && (rdata.prio < bprio_reg);
            else
                better = cand && (rdata.created < bcre_reg);
        end
    end

    // status of a point operation
    logic       reap_hit;
    logic [1:0] pt_status;
    assign reap_hit = (func_reg == FN_REAP) && (rdata.state == ST_ZOMBIE);
    always_comb
    begin
        case (func_reg)
            FN_SET_STATE: pt_status = (nst_reg > ST_ZOMBIE) ? RS_NONE : RS_OK;
            FN_SET_PRIO:
                pt_status = (pri_reg < 3'd1 || pri_reg > 3'(LEVELS)) ? RS_RANGE : RS_OK;
            FN_REAP:      pt_status = reap_hit ? RS_OK : RS_NONE;
            default:      pt_status = RS_OK;
        endcase
    end

    logic scan_first;  // first-hit policies stop at first hit
    assign scan_first = (func_reg == FN_ALLOC) ||
                        (policy_reg == PM_ROTATE) || (policy_reg == PM_LEVELS);

    // ram control and datapath
    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = raddr_reg;
        wdata = rdata;
        raddr = idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = cnt_reg[SW-1:0];
                wdata = '0;
                if (cnt_reg == (SW+1)'(SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                raddr = slot_index;
                if (in_valid && func != FN_NOP)
                    state_next = S_RD;
            end
            S_RD:
            begin
                raddr = idx_reg;
                if (func_reg == FN_ALLOC || func_reg == FN_TICK || func_reg == FN_SELECT)
                    state_next = S_SCAN;
                else
                    state_next = S_PT;
            end
            S_PT:
            begin
                waddr = idx_reg;
                case (func_reg)
                    FN_SET_STATE:
                    begin
                        we = (nst_reg <= ST_ZOMBIE);
                        wdata.state = nst_reg;
                    end
                    FN_SET_PRIO:
                    begin
                        we = (pri_reg >= 3'd1) && (pri_reg <= 3'(LEVELS));
                        wdata.prio = pri_reg[1:0];
                    end
                    FN_LOWER:
                    begin
                        we = 1'b1;
                        wdata.prio = (rdata.prio > 2'd1) ? rdata.prio - 2'd1 : 2'd1;
                    end
                    FN_REAP:
                    begin
                        we = (rdata.state == ST_ZOMBIE);
                        wdata = '0;
                    end
                    default: we = 1'b0;
                endcase
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                raddr = SW'(base_reg + cnt_reg[SW-1:0]);
                if (func_reg == FN_TICK && rvalid_reg)
                begin
                    we = 1'b1;
                    waddr = raddr_reg;
                    case (rdata.state)
                        ST_SLEEPING: wdata.sleep_cnt = rdata.sleep_cnt + 32'd1;
                        ST_RUNNABLE: wdata.ready_cnt = rdata.ready_cnt + 32'd1;
                        ST_RUNNING:  wdata.run_cnt   = rdata.run_cnt + 32'd1;
                        default:     we = 1'b0;
                    endcase
                end
                if (rcnt_reg == (SW+1)'(SLOTS) ||
                    (rvalid_reg && cand && scan_first && func_reg != FN_TICK))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                raddr = best_reg;
                state_next = (func_reg == FN_TICK) ? S_OUT : S_UPD;
                if (func_reg == FN_SELECT && policy_reg == PM_LEVELS && !found_reg
                    && lvl_reg > (LW+1)'(1))
                    state_next = S_SCAN;
            end
            S_UPD:
            begin
                waddr = best_reg;
                we = found_reg;
                if (func_reg == FN_ALLOC)
                begin
                    wdata = '0;
                    wdata.state = ST_EMBRYO;
                    wdata.id = next_id_reg;
                    wdata.created = tick_reg;
                    wdata.prio = 2'd2;
                end
                else
                    wdata.state = ST_RUNNING;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            policy_reg <= PM_ROTATE;
            next_id_reg <= 31'd1;
            tick_reg <= '0;
            rot_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
                lvl_ptr_reg[i] <= SW'(1 % SLOTS);
            cnt_reg <= '0;
            rcnt_reg <= '0;
            rvalid_reg <= 1'b0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                policy_reg <= cfg_wdata;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            raddr_reg <= raddr;
            case (state_reg)
                S_CLEAR: cnt_reg <= cnt_reg + 1'b1;
                S_IDLE:
                begin
                    func_reg <= func;
                    idx_reg <= slot_index;
                    nst_reg <= new_state;
                    pri_reg <= priority_value;
                    cnt_reg <= '0;
                    rcnt_reg <= '0;
                    rvalid_reg <= 1'b0;
                    found_reg <= 1'b0;
                    lvl_reg <= (LW+1)'(LEVELS);
                    base_reg <= '0;
                end
                S_RD:
                begin
                    if (func_reg == FN_SELECT && policy_reg == PM_ROTATE)
                        base_reg <= rot_reg;
                    else if (func_reg == FN_SELECT && policy_reg == PM_LEVELS)
                        base_reg <= lvl_ptr_reg[LEVELS-1];
                end
                S_SCAN:
                begin
                    if (cnt_reg != (SW+1)'(SLOTS))
                        cnt_reg <= cnt_reg + 1'b1;
                    rvalid_reg <= (cnt_reg != (SW+1)'(SLOTS)) && (state_next != S_FIN);
                    if (rvalid_reg)
                    begin
                        rcnt_reg <= rcnt_reg + 1'b1;
                        if (better && func_reg != FN_TICK && !(found_reg && scan_first))
                        begin
                            found_reg <= 1'b1;
                            best_reg <= raddr_reg;
                            bprio_reg <= rdata.prio;
                            bcre_reg <= rdata.created;
                            bid_reg <= rdata.id;
                        end
                    end
                end
                S_FIN:
                begin
                    if (state_next == S_SCAN)
                    begin
                        lvl_reg <= lvl_reg - 1'b1;
                        base_reg <= lvl_ptr_reg[LW'(lvl_reg - 2'd2)];
                        cnt_reg <= '0;
                        rcnt_reg <= '0;
                    end
                    res_reg <= '0;
                    if (func_reg == FN_TICK)
                    begin
                        tick_reg <= tick_reg + 32'd1;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_PT:
                begin
                    out_valid_reg <= 1'b1;
                    res_reg.status <= pt_status;
                    res_reg.chosen_slot <= '0;
                    res_reg.task_id <= reap_hit ? rdata.id : 31'd0;
                    res_reg.wait_ticks <= reap_hit ? rdata.ready_cnt : 32'd0;
                    res_reg.run_ticks <= reap_hit ? rdata.run_cnt : 32'd0;
                    res_reg.sleep_ticks <= reap_hit ? rdata.sleep_cnt : 32'd0;
                end
                S_UPD:
                begin
                    out_valid_reg <= 1'b1;
                    if (!found_reg)
                        res_reg.status <= RS_NONE;
                    else
                    begin
                        res_reg.chosen_slot <= 6'(best_reg);
                        if (func_reg == FN_ALLOC)
                        begin
                            res_reg.task_id <= next_id_reg;
                            next_id_reg <= next_id_reg + 31'd1;
                        end
                        else
                        begin
                            res_reg.task_id <= bid_reg;
                            if (policy_reg == PM_ROTATE)
                                rot_reg <= SW'(best_reg + 1'b1);
                            if (policy_reg == PM_LEVELS)
                                lvl_ptr_reg[LW'(lvl_reg - 1'b1)] <= SW'(best_reg + 1'b1);
                        end
                    end
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // checks on sequencing
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !we)
        else $error("ram write while idle");
endmodule
`default_nettype wire

FILE: design/pts_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: bench/process_table_scheduler_unit_tb.sv
// testbench for the process table scheduler: directed and random requests, self-checking
`timescale 1ns / 100ps
`default_nettype none
module process_table_scheduler_unit_tb
    import pts_pkg::*;
;

    // longest request is a multilevel select, up to LEVELS sweeps of the slot table
    localparam int SETTLE_CYCLES = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  func = '0;
    logic [5:0]  slot_index = '0;
    logic [2:0]  new_state = '0;
    logic [2:0]  priority_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [5:0]  chosen_slot;
    logic [30:0] task_id;
    logic [31:0] wait_ticks;
    logic [31:0] run_ticks;
    logic [31:0] sleep_ticks;

    process_table_scheduler_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .slot_index(slot_index), .new_state(new_state),
        .priority_value(priority_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .chosen_slot(chosen_slot), .task_id(task_id),
        .wait_ticks(wait_ticks), .run_ticks(run_ticks), .sleep_ticks(sleep_ticks)
    );

    always #5 clk = ~clk;

    // mirror of the slot table
    logic [2:0]  tbl_state   [SLOTS];
    logic [1:0]  tbl_prio    [SLOTS];
    logic [30:0] tbl_id      [SLOTS];
    logic [31:0] tbl_created [SLOTS];
    logic [31:0] tbl_ready   [SLOTS];
    logic [31:0] tbl_run     [SLOTS];
    logic [31:0] tbl_sleep   [SLOTS];
    logic [30:0] id_next;
    logic [31:0] now_tick;
    logic [5:0]  rr_ptr;
    logic [5:0]  lvl_ptr [LEVELS];
    logic [1:0]  policy;

    result_t pending_results[$];
    int  fail_count = 0;
    int  checked_count = 0;
    int  sent_count = 0;
    bit  idle_on = 1'b1;

    function automatic void model_reset();
        for (int s = 0; s < SLOTS; s++)
        begin
            tbl_state[s] = ST_UNUSED; tbl_prio[s] = '0; tbl_id[s] = '0;
            tbl_created[s] = '0; tbl_ready[s] = '0; tbl_run[s] = '0; tbl_sleep[s] = '0;
        end
        id_next = 31'd1;
        now_tick = '0;
        rr_ptr = '0;
        for (int l = 0; l < LEVELS; l++)
            lvl_ptr[l] = 6'd1;
        policy = PM_ROTATE;
    endfunction

    function automatic void clear_entry(int s);
        tbl_state[s] = ST_UNUSED; tbl_prio[s] = '0; tbl_id[s] = '0;
        tbl_created[s] = '0; tbl_ready[s] = '0; tbl_run[s] = '0; tbl_sleep[s] = '0;
    endfunction

    // pick the next slot to run under the current policy, -1 if none
    function automatic int pick_slot();
        int best;
        int s;
        best = -1;
        if (policy == PM_ROTATE)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                s = (rr_ptr + i) % SLOTS;
                if (tbl_state[s] == ST_RUNNABLE)
                begin
                    rr_ptr = 6'((s + 1) % SLOTS);
                    return s;
                end
            end
        end
        else if (policy == PM_LEVELS)
        begin
            for (int lv = LEVELS; lv >= 1; lv--)
                for (int i = 0; i < SLOTS; i++)
                begin
                    s = (lvl_ptr[lv-1] + i) % SLOTS;
                    if (tbl_state[s] == ST_RUNNABLE && tbl_prio[s] == lv)
                    begin
                        lvl_ptr[lv-1] = 6'((s + 1) % SLOTS);
                        return s;
                    end
                end
        end
        else
        begin
            for (s = 0; s < SLOTS; s++)
            begin
                if (tbl_state[s] != ST_RUNNABLE)
                    continue;
                if (best < 0)
                    best = s;
                else if (policy == PM_PRIO && tbl_prio[s] != tbl_prio[best])
                begin
                    if (tbl_prio[s] < tbl_prio[best])
                        best = s;
                end
                else if (tbl_created[s] < tbl_created[best])
                    best = s;
            end
        end
        return best;
    endfunction

    // apply one request to the mirror; returns 0 when no result is produced
    function automatic bit predict_result(input logic [2:0] f, input logic [5:0] idx,
                                          input logic [2:0] nst, input logic [2:0] pri,
                                          output result_t r);
        int pick;
        r = '0;
        pick = -1;
        case (f)
            FN_SET_STATE:
                if (nst > ST_ZOMBIE) r.status = RS_NONE;
                else tbl_state[idx] = nst;
            FN_SET_PRIO:
                if (pri < 1 || pri > LEVELS) r.status = RS_RANGE;
                else tbl_prio[idx] = pri[1:0];
            FN_LOWER:
                tbl_prio[idx] = (tbl_prio[idx] > 1) ? tbl_prio[idx] - 2'd1 : 2'd1;
            FN_ALLOC:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (pick < 0 && tbl_state[s] == ST_UNUSED)
                        pick = s;
                if (pick < 0)
                    r.status = RS_NONE;
                else
                begin
                    clear_entry(pick);
                    tbl_state[pick] = ST_EMBRYO;
                    tbl_id[pick] = id_next;
                    tbl_created[pick] = now_tick;
                    tbl_prio[pick] = 2'd2;
                    id_next = id_next + 31'd1;
                    r.chosen_slot = 6'(pick);
                    r.task_id = tbl_id[pick];
                end
            end
            FN_TICK:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (tbl_state[s] == ST_SLEEPING) tbl_sleep[s] = tbl_sleep[s] + 1;
                    else if (tbl_state[s] == ST_RUNNABLE) tbl_ready[s] = tbl_ready[s] + 1;
                    else if (tbl_state[s] == ST_RUNNING) tbl_run[s] = tbl_run[s] + 1;
                now_tick = now_tick + 1;
            end
            FN_SELECT:
            begin
                pick = pick_slot();
                if (pick < 0)
                    r.status = RS_NONE;
                else
                begin
                    tbl_state[pick] = ST_RUNNING;
                    r.chosen_slot = 6'(pick);
                    r.task_id = tbl_id[pick];
                end
            end
            FN_REAP:
                if (tbl_state[idx] != ST_ZOMBIE)
                    r.status = RS_NONE;
                else
                begin
                    r.task_id = tbl_id[idx];
                    r.wait_ticks = tbl_ready[idx];
                    r.run_ticks = tbl_run[idx];
                    r.sleep_ticks = tbl_sleep[idx];
                    clear_entry(idx);
                end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // result side: random stall bursts on out_ready
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (!idle_on)
            out_ready <= 1'b1;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_ready <= ($urandom_range(0, 2) != 0);
            stall_left <= $urandom_range(1, 16);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // compare each result against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                check_field("status", want.status, status);
                check_field("chosen_slot", want.chosen_slot, chosen_slot);
                check_field("task_id", want.task_id, task_id);
                check_field("wait_ticks", want.wait_ticks, wait_ticks);
                check_field("run_ticks", want.run_ticks, run_ticks);
                check_field("sleep_ticks", want.sleep_ticks, sleep_ticks);
            end
        end
    end

    // present one request and hold it until accepted
    task automatic send_req(logic [2:0] f, logic [5:0] idx, logic [2:0] nst, logic [2:0] pri);
        result_t r;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        slot_index <= idx;
        new_state <= nst;
        priority_value <= pri;
        do
            @(posedge clk);
        while (!in_ready);
        if (predict_result(f, idx, nst, pri, r))
            pending_results.push_back(r);
        sent_count++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_policy(logic [1:0] mode);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        policy = mode;
    endtask

    // allocation, state codes, priority range and lowering, with an empty select and reap, a tick and a nop
    task automatic test_table_basics();
        send_req(FN_SELECT, 0, 0, 0);
        send_req(FN_REAP, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            send_req(FN_ALLOC, 0, 0, 0);
        send_req(FN_SET_STATE, 0, ST_RUNNABLE, 0);
        send_req(FN_SET_STATE, 1, 3'd6, 0);
        send_req(FN_SET_STATE, 2, 3'd7, 0);
        send_req(FN_SET_STATE, 63, ST_RUNNABLE, 0);
        send_req(FN_SET_PRIO, 1, 0, 3'd0);
        send_req(FN_SET_PRIO, 1, 0, 3'd4);
        send_req(FN_SET_PRIO, 1, 0, 3'd7);
        send_req(FN_SET_PRIO, 1, 0, 3'd3);
        send_req(FN_SET_PRIO, 63, 0, 3'd1);
        send_req(FN_LOWER, 1, 0, 0);
        send_req(FN_LOWER, 63, 0, 0);
        send_req(FN_LOWER, 5, 0, 0);
        send_req(FN_SET_STATE, 2, ST_SLEEPING, 0);
        send_req(FN_SET_STATE, 3, ST_RUNNABLE, 0);
        send_req(FN_TICK, 0, 0, 0);
        send_req(FN_NOP, 6'h3f, 3'h7, 3'h7);
    endtask

    // two selects under each policy, then reap a zombie and a live slot
    task automatic test_policies_and_reap();
        for (int m = 0; m < 4; m++)
        begin
            write_policy(2'(m));
            send_req(FN_SET_STATE, 0, ST_RUNNABLE, 0);
            send_req(FN_SET_STATE, 3, ST_RUNNABLE, 0);
            send_req(FN_SELECT, 0, 0, 0);
            send_req(FN_SELECT, 0, 0, 0);
        end
        send_req(FN_SET_STATE, 2, ST_ZOMBIE, 0);
        send_req(FN_REAP, 2, 0, 0);
        send_req(FN_REAP, 3, 0, 0);
    endtask

    // mostly well-formed lifecycles on low slots, some noise
    task automatic random_req();
        int w;
        logic [5:0] idx;
        w = $urandom_range(0, 99);
        idx = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
        if (w < 14) send_req(FN_ALLOC, idx, 3'($urandom), 3'($urandom));
        else if (w < 34)
            send_req(FN_SET_STATE, idx, ($urandom_range(0, 9) == 0) ? 3'($urandom)
                     : 3'($urandom_range(ST_SLEEPING, ST_ZOMBIE)), 3'($urandom));
        else if (w < 50) send_req(FN_TICK, idx, 3'($urandom), 3'($urandom));
        else if (w < 70) send_req(FN_SELECT, idx, 3'($urandom), 3'($urandom));
        else if (w < 81) send_req(FN_REAP, idx, 3'($urandom), 3'($urandom));
        else if (w < 91)
            send_req(FN_SET_PRIO, idx, 3'($urandom), ($urandom_range(0, 5) == 0) ?
                     3'($urandom) : 3'($urandom_range(1, 3)));
        else if (w < 97) send_req(FN_LOWER, idx, 3'($urandom), 3'($urandom));
        else send_req(FN_NOP, idx, 3'($urandom), 3'($urandom));
    endtask

    task automatic test_random();
        logic [1:0] order [4] = '{PM_LEVELS, PM_ROTATE, PM_PRIO, PM_OLDEST};
        foreach (order[p])
        begin
            write_policy(order[p]);
            for (int i = 0; i < 62; i++)
                random_req();
            drain();
            for (int i = 0; i < 62; i++)
                random_req();
        end
    endtask

    // fill the whole table so allocate runs out of slots, no idling here
    task automatic test_full_table();
        idle_on = 1'b0;
        for (int i = 0; i < SLOTS + 1; i++)
            send_req(FN_ALLOC, 0, 0, 0);
        send_req(FN_SET_STATE, 63, ST_RUNNABLE, 0);
        send_req(FN_SET_PRIO, 63, 0, 3'd3);
        send_req(FN_SELECT, 0, 0, 0);
        send_req(FN_SET_STATE, 63, ST_ZOMBIE, 0);
        send_req(FN_REAP, 63, 0, 0);
    endtask

    initial
    begin
        model_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_basics();
        test_policies_and_reap();
        test_random();
        test_full_table();
        drain();
        $display("covered %0d requests and %0d checked results across all four policies,",
                 sent_count, checked_count);
        $display("including bad codes, priority range, reap of zombies and a full table");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
design/pts_pkg.sv
design/pts_ram.sv
design/process_table_scheduler_unit.sv
bench/process_table_scheduler_unit_tb.sv
